### hdl/vital_sign_alarm_monitor_top_assert.svh
// Assertion macros shared by the vital-sign alarm monitor RTL.
`ifndef VITAL_SIGN_ALARM_MONITOR_TOP_ASSERT_SVH
`define VITAL_SIGN_ALARM_MONITOR_TOP_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define VSAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define VSAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vsam_pkg.sv
// Types and constants of the vital-sign alarm monitor.
package vsam_pkg;

  // request kinds
  localparam logic [1:0] REQ_NONE    = 2'd0;
  localparam logic [1:0] REQ_READING = 2'd1;
  localparam logic [1:0] REQ_MODE    = 2'd2;
  localparam logic [1:0] REQ_ALARM   = 2'd3;

  // event codes
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_SENSOR   = 4'd1;
  localparam logic [3:0] EV_SEVERE   = 4'd2;
  localparam logic [3:0] EV_LOW_RESP = 4'd3;
  localparam logic [3:0] EV_LOW_SPO2 = 4'd4;
  localparam logic [3:0] EV_HR_RANGE = 4'd5;
  localparam logic [3:0] EV_MODE     = 4'd6;
  localparam logic [3:0] EV_ALARM    = 4'd7;
  localparam logic [3:0] EV_SAVE     = 4'd8;

  // actuator commands
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  localparam logic [31:0] SAVE_INTERVAL_RESET = 32'd5000;

  // threshold sets, index 0 child, index 1 adult
  localparam logic [6:0] SPO2_MIN_TAB  [2] = '{7'd93, 7'd90};
  localparam logic [7:0] RR_MIN_TAB    [2] = '{8'd20, 8'd12};
  localparam logic [7:0] RR_SEVERE_TAB [2] = '{8'd12, 8'd8};
  localparam logic [8:0] HR_MIN_TAB    [2] = '{9'd80, 9'd60};
  localparam logic [8:0] HR_MAX_TAB    [2] = '{9'd130, 9'd100};

  typedef struct packed {
    logic [1:0]  req_type;
    logic        reading_valid;
    logic [7:0]  resp_rate;
    logic [6:0]  oxygen_sat;
    logic [8:0]  heart_rate;
    logic [31:0] now_ms;
  } vsam_item_t;

  typedef struct packed {
    logic        adult_mode;
    logic [31:0] last_save_time;
    logic [31:0] apnea_counter;
    logic [31:0] low_oxygen_counter;
    logic [31:0] cardiac_counter;
  } vsam_state_t;

  typedef struct packed {
    logic [3:0]  event_code;
    logic [1:0]  alarm_cmd;
    logic        mode_changed;
    logic        adult_active;
    logic        save_now;
    logic [31:0] apnea_total;
    logic [31:0] low_oxygen_total;
    logic [31:0] cardiac_total;
  } vsam_result_t;

endpackage

### hdl/vsam_req_if.sv
// Request channel of the vital-sign alarm monitor: one update step per word.
interface vsam_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        reading_valid;
  logic [7:0]  resp_rate;
  logic [6:0]  oxygen_sat;
  logic [8:0]  heart_rate;
  logic [31:0] now_ms;

  modport source (
    output valid, req_type, reading_valid, resp_rate, oxygen_sat, heart_rate, now_ms,
    input  ready
  );
  modport sink (
    input  valid, req_type, reading_valid, resp_rate, oxygen_sat, heart_rate, now_ms,
    output ready
  );
endinterface

### hdl/vsam_res_if.sv
// Result channel of the vital-sign alarm monitor: one report per word.
interface vsam_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_code;
  logic [1:0]  alarm_cmd;
  logic        mode_changed;
  logic        adult_active;
  logic        save_now;
  logic [31:0] apnea_total;
  logic [31:0] low_oxygen_total;
  logic [31:0] cardiac_total;

  modport source (
    output valid, event_code, alarm_cmd, mode_changed, adult_active, save_now,
           apnea_total, low_oxygen_total, cardiac_total,
    input  ready
  );
  modport sink (
    input  valid, event_code, alarm_cmd, mode_changed, adult_active, save_now,
           apnea_total, low_oxygen_total, cardiac_total,
    output ready
  );
endinterface

### hdl/vsam_eval.sv
// Step evaluator: classify one request, pick the event and form the next state.
module vsam_eval (
  input  vsam_pkg::vsam_item_t   item,
  input  vsam_pkg::vsam_state_t  cur,
  input  logic [31:0]            save_interval_ms,
  output vsam_pkg::vsam_result_t result,
  output vsam_pkg::vsam_state_t  state_next
);
  import vsam_pkg::*;

  logic        m;
  logic [3:0]  cls;
  logic [3:0]  ev;
  logic [31:0] elapsed;

  assign m       = cur.adult_mode;
  assign elapsed = item.now_ms - cur.last_save_time;

  // reading checks in priority order
  always_comb begin
    if (!item.reading_valid) begin
      cls = EV_SENSOR;
    end else if (item.resp_rate < RR_SEVERE_TAB[m]) begin
      cls = EV_SEVERE;
    end else if (item.resp_rate < RR_MIN_TAB[m]) begin
      cls = EV_LOW_RESP;
    end else if (item.oxygen_sat < SPO2_MIN_TAB[m]) begin
      cls = EV_LOW_SPO2;
    end else if (item.heart_rate < HR_MIN_TAB[m] || item.heart_rate > HR_MAX_TAB[m]) begin
      cls = EV_HR_RANGE;
    end else begin
      cls = EV_NONE;
    end
  end

  always_comb begin
    case (item.req_type)
      REQ_READING: ev = cls;
      REQ_MODE:    ev = EV_MODE;
      REQ_ALARM:   ev = EV_ALARM;
      default:     ev = EV_NONE;
    endcase
    // an idle step or a clean reading turns into a save once the interval has run out
    if (ev == EV_NONE && elapsed >= save_interval_ms) begin
      ev = EV_SAVE;
    end

    state_next          = cur;
    result.alarm_cmd    = CMD_NONE;
    result.mode_changed = 1'b0;
    result.save_now     = 1'b0;
    case (ev)
      EV_MODE: begin
        state_next.adult_mode = ~cur.adult_mode;
        result.mode_changed   = 1'b1;
      end
      EV_ALARM: begin
        result.alarm_cmd = CMD_OFF;
      end
      EV_SEVERE: begin
        state_next.apnea_counter = cur.apnea_counter + 32'd1;
        result.alarm_cmd         = CMD_ON;
      end
      EV_LOW_RESP: begin
        state_next.apnea_counter = cur.apnea_counter + 32'd1;
      end
      EV_LOW_SPO2: begin
        state_next.low_oxygen_counter = cur.low_oxygen_counter + 32'd1;
      end
      EV_HR_RANGE: begin
        state_next.cardiac_counter = cur.cardiac_counter + 32'd1;
      end
      EV_SAVE: begin
        state_next.last_save_time = item.now_ms;
        result.save_now           = 1'b1;
      end
      default: begin
      end
    endcase

    result.event_code       = ev;
    result.adult_active     = state_next.adult_mode;
    result.apnea_total      = state_next.apnea_counter;
    result.low_oxygen_total = state_next.low_oxygen_counter;
    result.cardiac_total    = state_next.cardiac_counter;
  end

endmodule

### hdl/vital_sign_alarm_monitor_top.sv
// Top level of the vital-sign alarm monitor: staging registers, state and evaluator.
//
// Each request word is one update step: an idle tick, a vital-sign reading, a mode
// button press or an alarm button press, stamped with the millisecond time now_ms.
// Every accepted word yields exactly one report word, in order, carrying the event
// code, the actuator command, the mode flags, the save strobe and the three event
// counters after the step. Readings are checked against the child or adult threshold
// set; an idle step or a clean reading becomes a save once save_interval_ms has
// elapsed since the last save (wrapping 32-bit time). The block takes one word every
// clock while the sink keeps up: a word sits in the input register, the evaluator
// classifies it combinationally, and the report is loaded into the result register,
// which drives report valid, as the state register takes the new mode, counters and
// save time. The classify-and-count path between the input and result registers is
// combinational. The result register holds a report while the sink stalls and the
// input register keeps accepting until both are full. Write save_interval_ms through
// cfg_we / cfg_wdata only while the block is idle; it resets to 5000.
module vital_sign_alarm_monitor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  vsam_req_if.sink    request,
  vsam_res_if.source  report
);
  import vsam_pkg::*;

  `include "vital_sign_alarm_monitor_top_assert.svh"

  logic [31:0]  save_interval_ms;
  logic         in_valid;
  vsam_item_t   in_item;
  logic         out_valid;
  vsam_result_t out_res;
  vsam_state_t  state;
  vsam_state_t  state_next;
  vsam_result_t result;
  logic         advance;

  // move the staged word into the result register when that slot is free
  assign advance       = in_valid && (!out_valid || report.ready);
  assign request.ready = !in_valid || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      save_interval_ms <= SAVE_INTERVAL_RESET;
    end else if (cfg_we) begin
      save_interval_ms <= cfg_wdata;
    end
  end

  // input register: hold a word until the evaluator takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (request.ready) begin
      in_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.ready && request.valid) begin
      in_item.req_type      <= request.req_type;
      in_item.reading_valid <= request.reading_valid;
      in_item.resp_rate     <= request.resp_rate;
      in_item.oxygen_sat    <= request.oxygen_sat;
      in_item.heart_rate    <= request.heart_rate;
      in_item.now_ms        <= request.now_ms;
    end
  end

  vsam_eval u_eval (
    .item             (in_item),
    .cur              (state),
    .save_interval_ms (save_interval_ms),
    .result           (result),
    .state_next       (state_next)
  );

  // mode, save time and counters advance once per evaluated word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register: hold the report while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign report.valid            = out_valid;
  assign report.event_code       = out_res.event_code;
  assign report.alarm_cmd        = out_res.alarm_cmd;
  assign report.mode_changed     = out_res.mode_changed;
  assign report.adult_active     = out_res.adult_active;
  assign report.save_now         = out_res.save_now;
  assign report.apnea_total      = out_res.apnea_total;
  assign report.low_oxygen_total = out_res.low_oxygen_total;
  assign report.cardiac_total    = out_res.cardiac_total;

  `VSAM_ASSERT_NEXT(a_mode_hold, advance && !result.mode_changed,
    state.adult_mode == $past(state.adult_mode), "mode moved without a toggle")
  `VSAM_ASSERT_NEXT(a_save_time, advance && result.save_now,
    state.last_save_time == $past(in_item.now_ms), "save time not taken from the saving step")
  `VSAM_ASSERT_NOW(a_alarm_on, out_valid,
    (out_res.alarm_cmd == CMD_ON) == (out_res.event_code == EV_SEVERE),
    "alarm on without severe event")
  `VSAM_ASSERT_NOW(a_save_strobe, out_valid,
    out_res.save_now == (out_res.event_code == EV_SAVE), "save strobe out of step with event")
  `VSAM_ASSERT_NOW(a_full_stall, in_valid && !advance, !request.ready,
    "word accepted into a full input register")

endmodule

### tb/sv/vital_sign_alarm_monitor_top_tb.sv
// Self-checking testbench of the vital-sign alarm monitor: directed and random update steps.
`timescale 1ns / 100ps

module vital_sign_alarm_monitor_top_tb;
  import vsam_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  vsam_req_if req_ch ();
  vsam_res_if rep_ch ();

  vital_sign_alarm_monitor_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (req_ch),
    .report    (rep_ch)
  );

  // 8 ns clock, low first.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the monitor: mode, save mark, the three counters and the interval
  // register. Touched only by the predictor and by the interval writes, which
  // happen while the block is idle.
  // ---------------------------------------------------------------------------
  logic        adult_now;
  logic [31:0] save_mark_ms;
  logic [31:0] apnea_cnt;
  logic [31:0] low_ox_cnt;
  logic [31:0] cardiac_cnt;
  logic [31:0] save_gap_ms;

  vsam_item_t   step_q[$];           // steps still to be offered by the driver
  vsam_result_t predicted_reports[$]; // reports owed by the block, oldest first
  vsam_item_t   drive_word;

  logic [31:0] clock_ms;             // running millisecond time for random steps
  logic        req_took;             // request word accepted at the last rising edge
  logic        sender_idle;
  logic        sink_idle;
  int unsigned send_wait;
  int unsigned sink_wait;
  int unsigned hold_left;
  logic        hold_done;

  int fails;
  int steps_taken;
  int reports_seen;
  int stalled_cycles;
  int seen_ev [9];

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the shadow by one update step and return the report it yields.
  function automatic vsam_result_t predict_step(input vsam_item_t w);
    vsam_result_t r;
    logic [3:0]   ev;
    logic [31:0]  elapsed;
    logic [7:0]   resp_severe;
    logic [7:0]   resp_low;
    logic [6:0]   ox_low;
    logic [8:0]   hr_low;
    logic [8:0]   hr_high;
    r = '0;
    // Adult thresholds when adult_now is set, child thresholds otherwise.
    resp_severe = adult_now ? 8'd8   : 8'd12;
    resp_low    = adult_now ? 8'd12  : 8'd20;
    ox_low      = adult_now ? 7'd90  : 7'd93;
    hr_low      = adult_now ? 9'd60  : 9'd80;
    hr_high     = adult_now ? 9'd100 : 9'd130;

    case (w.req_type)
      REQ_READING: begin
        // First failing check in priority order decides the event.
        if (!w.reading_valid)                                   ev = EV_SENSOR;
        else if (w.resp_rate < resp_severe)                     ev = EV_SEVERE;
        else if (w.resp_rate < resp_low)                        ev = EV_LOW_RESP;
        else if (w.oxygen_sat < ox_low)                         ev = EV_LOW_SPO2;
        else if (w.heart_rate < hr_low || w.heart_rate > hr_high) ev = EV_HR_RANGE;
        else                                                    ev = EV_NONE;
      end
      REQ_MODE:  ev = EV_MODE;
      REQ_ALARM: ev = EV_ALARM;
      default:   ev = EV_NONE;
    endcase

    // A quiet step turns into a save once the interval has run out (wrapping time).
    elapsed = w.now_ms - save_mark_ms;
    if (ev == EV_NONE && elapsed >= save_gap_ms) begin
      ev = EV_SAVE;
      save_mark_ms = w.now_ms;
    end

    case (ev)
      EV_MODE: begin
        adult_now = ~adult_now;
        r.mode_changed = 1'b1;
      end
      EV_ALARM:    r.alarm_cmd = CMD_OFF;
      EV_SEVERE: begin
        apnea_cnt = apnea_cnt + 32'd1;
        r.alarm_cmd = CMD_ON;
      end
      EV_LOW_RESP: apnea_cnt = apnea_cnt + 32'd1;
      EV_LOW_SPO2: low_ox_cnt = low_ox_cnt + 32'd1;
      EV_HR_RANGE: cardiac_cnt = cardiac_cnt + 32'd1;
      EV_SAVE:     r.save_now = 1'b1;
      default: ;
    endcase

    r.event_code       = ev;
    r.adult_active     = adult_now;
    r.apnea_total      = apnea_cnt;
    r.low_oxygen_total = low_ox_cnt;
    r.cardiac_total    = cardiac_cnt;
    return r;
  endfunction

  // One random step. Readings sit mostly near the thresholds; now and then every
  // field takes its full range. Time mostly creeps forward, sometimes jumps anywhere.
  function automatic vsam_item_t random_step();
    vsam_item_t  w;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)      w.req_type = REQ_READING;
    else if (r < 70) w.req_type = REQ_NONE;
    else if (r < 85) w.req_type = REQ_ALARM;
    else             w.req_type = REQ_MODE;
    w.reading_valid = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 4) == 0) begin
      w.resp_rate  = 8'($urandom_range(0, 255));
      w.oxygen_sat = 7'($urandom_range(0, 127));
      w.heart_rate = 9'($urandom_range(0, 511));
    end else begin
      w.resp_rate  = 8'($urandom_range(0, 30));
      w.oxygen_sat = 7'($urandom_range(84, 100));
      w.heart_rate = 9'($urandom_range(50, 140));
    end
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else                            clock_ms = clock_ms + $urandom_range(0, 1500);
    w.now_ms = clock_ms;
    return w;
  endfunction

  task automatic queue_step(input logic [1:0] kind, input logic ok, input logic [7:0] rr,
                            input logic [6:0] ox, input logic [8:0] hr,
                            input logic [31:0] at_ms);
    vsam_item_t w;
    w.req_type      = kind;
    w.reading_valid = ok;
    w.resp_rate     = rr;
    w.oxygen_sat    = ox;
    w.heart_rate    = hr;
    w.now_ms        = at_ms;
    step_q.push_back(w);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  // Hold until every queued step is taken and every report has come back, then
  // let the input and result registers settle before touching the interval register.
  task automatic drain();
    while (step_q.size() != 0 || req_ch.valid || predicted_reports.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_interval(input logic [31:0] ms);
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= ms;
    save_gap_ms = ms;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n);
    @(posedge clk);
    repeat (n) step_q.push_back(random_step());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next step at the falling edge once the previous word has
  // been taken, with a random gap after each accepted word while sender_idle is set.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_took) begin
      if (send_wait != 0) begin
        send_wait = send_wait - 1;
        req_ch.valid <= 1'b0;
      end else if (step_q.size() != 0) begin
        drive_word = step_q.pop_front();
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= drive_word.req_type;
        req_ch.reading_valid <= drive_word.reading_valid;
        req_ch.resp_rate     <= drive_word.resp_rate;
        req_ch.oxygen_sat    <= drive_word.oxygen_sat;
        req_ch.heart_rate    <= drive_word.heart_rate;
        req_ch.now_ms        <= drive_word.now_ms;
        send_wait = sender_idle ? idle_len() : 0;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Sink: drop ready for random stretches while sink_idle is set, and for the whole of the long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      rep_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rep_ch.ready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait = sink_wait - 1;
      rep_ch.ready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 3) == 0) begin
      sink_wait = idle_len();
      rep_ch.ready <= (sink_wait == 0);
    end else begin
      rep_ch.ready <= 1'b1;
    end
  end

  // Long hold-off: once a few dozen reports are in, refuse reports while hold_left
  // counts down and the driver keeps offering, so both staging registers fill and
  // the request side stalls.
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && reports_seen >= 50) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge check an accepted report against the oldest
  // prediction, then predict the report of an accepted request word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    vsam_result_t want;
    req_took <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && rep_ch.valid && rep_ch.ready) begin
      reports_seen++;
      if (predicted_reports.size() == 0) begin
        $display("%0t ns: report word with nothing expected, event_code %0d",
                 $time, rep_ch.event_code);
        fails++;
      end else begin
        want = predicted_reports.pop_front();
        check_field("event_code",       want.event_code,       rep_ch.event_code);
        check_field("alarm_cmd",        want.alarm_cmd,        rep_ch.alarm_cmd);
        check_field("mode_changed",     want.mode_changed,     rep_ch.mode_changed);
        check_field("adult_active",     want.adult_active,     rep_ch.adult_active);
        check_field("save_now",         want.save_now,         rep_ch.save_now);
        check_field("apnea_total",      want.apnea_total,      rep_ch.apnea_total);
        check_field("low_oxygen_total", want.low_oxygen_total, rep_ch.low_oxygen_total);
        check_field("cardiac_total",    want.cardiac_total,    rep_ch.cardiac_total);
        if (want.event_code <= EV_SAVE) seen_ev[want.event_code]++;
      end
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      steps_taken++;
      predicted_reports.push_back(predict_step('{req_type:      req_ch.req_type,
                                                 reading_valid: req_ch.reading_valid,
                                                 resp_rate:     req_ch.resp_rate,
                                                 oxygen_sat:    req_ch.oxygen_sat,
                                                 heart_rate:    req_ch.heart_rate,
                                                 now_ms:        req_ch.now_ms}));
    end
    if (!rst && hold_left != 0 && req_ch.valid && !req_ch.ready) stalled_cycles++;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("timeout after %0d steps and %0d reports", steps_taken, reports_seen);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Drive every input known from time zero and hold reset.
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_NONE;
    req_ch.reading_valid = 1'b0;
    req_ch.resp_rate     = '0;
    req_ch.oxygen_sat    = '0;
    req_ch.heart_rate    = '0;
    req_ch.now_ms        = '0;
    rep_ch.ready         = 1'b0;
    req_took             = 1'b0;
    send_wait            = 0;
    sink_wait            = 0;
    hold_left            = 0;
    hold_done            = 1'b0;
    sender_idle          = 1'b1;
    sink_idle            = 1'b1;
    fails                = 0;
    steps_taken          = 0;
    reports_seen         = 0;
    stalled_cycles       = 0;
    foreach (seen_ev[i]) seen_ev[i] = 0;
    clock_ms             = 32'd20000;

    // Shadow state after reset.
    adult_now    = 1'b0;
    save_mark_ms = '0;
    apnea_cnt    = '0;
    low_ox_cnt   = '0;
    cardiac_cnt  = '0;
    save_gap_ms  = SAVE_INTERVAL_RESET;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed steps at the reset interval, child mode first.
    @(posedge clk);
    queue_step(REQ_NONE,    1'b0, 8'd0,   7'd0,   9'd0,   32'd0);         // quiet, no save
    queue_step(REQ_NONE,    1'b1, 8'd255, 7'd127, 9'd511, 32'd4999);      // one short of a save
    queue_step(REQ_NONE,    1'b0, 8'd0,   7'd0,   9'd0,   32'd5000);      // interval just elapsed
    // invalid reading with the interval long gone: error wins, save waits
    queue_step(REQ_READING, 1'b0, 8'd255, 7'd127, 9'd511, 32'hFFFF_FFFF);
    queue_step(REQ_READING, 1'b1, 8'd0,   7'd100, 9'd100, 32'd10);        // severe, alarm on
    queue_step(REQ_READING, 1'b1, 8'd11,  7'd100, 9'd100, 32'd10);        // severe edge
    queue_step(REQ_READING, 1'b1, 8'd12,  7'd0,   9'd0,   32'd10);        // low resp edge
    queue_step(REQ_READING, 1'b1, 8'd19,  7'd100, 9'd100, 32'd10);
    queue_step(REQ_READING, 1'b1, 8'd20,  7'd92,  9'd511, 32'd10);        // low SpO2 edge
    queue_step(REQ_READING, 1'b1, 8'd20,  7'd93,  9'd79,  32'd10);        // HR low edge
    queue_step(REQ_READING, 1'b1, 8'd20,  7'd93,  9'd131, 32'd10);        // HR high edge
    queue_step(REQ_READING, 1'b1, 8'd255, 7'd127, 9'd130, 32'd9999);      // all fine, no save
    queue_step(REQ_READING, 1'b1, 8'd20,  7'd93,  9'd80,  32'd10000);     // all fine, saves
    queue_step(REQ_ALARM,   1'b1, 8'd0,   7'd0,   9'd0,   32'd10000);     // alarm off
    queue_step(REQ_MODE,    1'b0, 8'd0,   7'd0,   9'd0,   32'd10000);     // to adult
    queue_step(REQ_READING, 1'b1, 8'd7,   7'd100, 9'd80,  32'd10001);     // adult severe edge
    queue_step(REQ_READING, 1'b1, 8'd8,   7'd100, 9'd80,  32'd10001);     // adult low resp
    queue_step(REQ_READING, 1'b1, 8'd11,  7'd100, 9'd80,  32'd10001);
    queue_step(REQ_READING, 1'b1, 8'd12,  7'd89,  9'd80,  32'd10001);     // adult low SpO2
    queue_step(REQ_READING, 1'b1, 8'd12,  7'd90,  9'd59,  32'd10001);     // adult HR low
    queue_step(REQ_READING, 1'b1, 8'd12,  7'd90,  9'd101, 32'd10001);     // adult HR high
    queue_step(REQ_READING, 1'b1, 8'd12,  7'd90,  9'd60,  32'd10001);     // adult limits met
    queue_step(REQ_READING, 1'b1, 8'd12,  7'd90,  9'd100, 32'd10001);
    queue_step(REQ_NONE,    1'b1, 8'd0,   7'd0,   9'd0,   32'hFFFF_FFFF); // save at top of time
    queue_step(REQ_MODE,    1'b1, 8'd255, 7'd127, 9'd511, 32'hFFFF_FFFF); // back to child
    queue_step(REQ_NONE,    1'b0, 8'd0,   7'd0,   9'd0,   32'h0000_0010); // time wrapped, no save
    drain();

    // Reset interval, idling on both sides; the long sink hold-off lands here.
    run_random(100);

    // Zero interval: every quiet step saves. No idling at all.
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    write_interval(32'd0);
    run_random(80);

    // Interval of one millisecond, gaps on the request side only.
    sender_idle = 1'b1;
    write_interval(32'd1);
    run_random(80);

    // Longest interval: only an elapsed time of all ones saves. Sink stalls only.
    sender_idle = 1'b0;
    sink_idle   = 1'b1;
    write_interval(32'hFFFF_FFFF);
    @(posedge clk);
    queue_step(REQ_NONE, 1'b0, 8'd0, 7'd0, 9'd0, save_mark_ms + 32'hFFFF_FFFE);
    queue_step(REQ_NONE, 1'b1, 8'd0, 7'd0, 9'd0, save_mark_ms + 32'hFFFF_FFFF);
    run_random(80);

    // A mid-range interval, then back to the reset value, idling everywhere.
    sender_idle = 1'b1;
    write_interval($urandom_range(100, 3000));
    run_random(80);
    write_interval(SAVE_INTERVAL_RESET);
    run_random(80);

    $display("run covered %0d steps / %0d reports: %0d saves, %0d mode toggles, %0d alarm-on",
             steps_taken, reports_seen, seen_ev[EV_SAVE], seen_ev[EV_MODE], seen_ev[EV_SEVERE]);
    $display("save intervals 0, 1, 5000, max and mid-range; request stalled %0d cycles in hold-off",
             stalled_cycles);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/vsam_pkg.sv
hdl/vsam_req_if.sv
hdl/vsam_res_if.sv
hdl/vsam_eval.sv
hdl/vital_sign_alarm_monitor_top.sv
tb/sv/vital_sign_alarm_monitor_top_tb.sv
